[hdl/chse_pkg.sv]
package chse_pkg;

  localparam int FRAC_BITS = 16;

  // numerator polynomial needs at most 164 signed bits for any FRAC_BITS up to 24
  localparam int NUM_W = 166;
  localparam int MUL_W = 34;
  localparam int NCH   = (NUM_W + 31) / 32;
  localparam int EXT_W = NCH * 32;
  localparam int PP_W  = 32 + MUL_W;
  localparam int QUO_W = 33;
  localparam int REM_W = NUM_W + QUO_W;

  // register stages of the polynomial pipe and of the divider
  localparam int POLY_NS = 14;
  localparam int DIV_NS  = QUO_W + 3;

  typedef enum logic [1:0] {
    CMD_VALUE = 2'd0,
    CMD_SLOPE = 2'd1,
    CMD_CURV  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] start_point;
    logic signed [31:0] end_point;
    logic signed [31:0] start_tangent;
    logic signed [31:0] end_tangent;
    logic signed [31:0] start_time;
    logic signed [31:0] end_time;
    logic signed [31:0] eval_time;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               saturated;
    logic               bad_interval;
  } rsp_t;

  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic signed [MUL_W-1:0] mul_t;
  typedef logic [NCH-1:0][PP_W-1:0] pp_t;

  // numerator and denominator handed from the polynomial pipe to the divider
  typedef struct packed {
    num_t num;
    num_t den;
    logic bad;
    logic zero;
  } pd_t;

  // one 32-bit slice of x times m per partial product, top slice signed
  function automatic pp_t mul_part(num_t x, mul_t m);
    logic [EXT_W-1:0]       xe;
    logic signed [32:0]     c;
    logic signed [PP_W-1:0] prod;
    pp_t                    pp;
    xe = EXT_W'(x);
    for (int k = 0; k < NCH; k++) begin
      if (k == NCH - 1) begin
        c = {xe[32*k+31], xe[32*k +: 32]};
      end else begin
        c = {1'b0, xe[32*k +: 32]};
      end
      prod  = PP_W'(c) * PP_W'(m);
      pp[k] = prod;
    end
    return pp;
  endfunction

  function automatic num_t mul_sum(pp_t pp, num_t a);
    logic [EXT_W-1:0] acc;
    acc = EXT_W'(a);
    for (int k = 0; k < NCH; k++) begin
      acc = acc + (EXT_W'($signed(pp[k])) << (32 * k));
    end
    return acc[NUM_W-1:0];
  endfunction

endpackage

[hdl/chse_poly.sv]
module chse_poly (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  chse_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output chse_pkg::pd_t  out_pd_o
);

  typedef struct packed {
    chse_pkg::cmd_e     cmd;
    logic               bad;
    logic signed [32:0] d;
    logic signed [32:0] u;
    logic signed [32:0] dp;
    logic signed [32:0] tv;
    logic signed [33:0] sv;
    logic signed [31:0] v0;
    logic signed [31:0] p0;
    chse_pkg::num_t     x0;
    chse_pkg::num_t     x1;
    chse_pkg::num_t     x2;
    chse_pkg::num_t     x3;
    chse_pkg::num_t     x4;
    chse_pkg::num_t     den;
    chse_pkg::pp_t      pa;
    chse_pkg::pp_t      pb;
  } poly_t;

  poly_t                         st_q [chse_pkg::POLY_NS];
  poly_t                         st_d [chse_pkg::POLY_NS];
  logic [chse_pkg::POLY_NS-1:0]  v_q;
  logic [chse_pkg::POLY_NS:0]    rdy;

  always_comb begin
    rdy[chse_pkg::POLY_NS] = out_ready_i;
    for (int k = chse_pkg::POLY_NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[chse_pkg::POLY_NS-1];

  always_comb begin
    poly_t              s;
    poly_t              n;
    logic signed [65:0] p_dd;
    logic signed [65:0] p_td;
    logic signed [66:0] p_sd;
    chse_pkg::num_t     t3;
    chse_pkg::num_t     a3x;

    s         = '0;
    p_dd      = '0;
    p_td      = '0;
    p_sd      = '0;
    t3        = '0;
    a3x       = '0;
    n         = '0;
    n.cmd     = in_req_i.command;
    n.d       = 33'(in_req_i.end_time) - 33'(in_req_i.start_time);
    n.u       = 33'(in_req_i.eval_time) - 33'(in_req_i.start_time);
    n.dp      = 33'(in_req_i.end_point) - 33'(in_req_i.start_point);
    n.tv      = 33'(in_req_i.end_tangent) + 33'(in_req_i.start_tangent);
    n.sv      = 34'(in_req_i.end_tangent) + (34'(in_req_i.start_tangent) <<< 1);
    n.v0      = in_req_i.start_tangent;
    n.p0      = in_req_i.start_point;
    n.bad     = (n.d <= 33'sd0);
    st_d[0]   = n;

    for (int k = 1; k < chse_pkg::POLY_NS; k++) begin
      s = st_q[k-1];
      n = s;
      case (k)
        1: begin
          p_dd = 66'(s.d) * 66'(s.d);
          p_td = 66'(s.tv) * 66'(s.d);
          p_sd = 67'(s.sv) * 67'(s.d);
          n.x0 = chse_pkg::NUM_W'(p_dd);
          n.x1 = chse_pkg::NUM_W'(p_td);
          n.x2 = chse_pkg::NUM_W'(p_sd);
        end
        2: begin
          // A = tv*d - 2S*dp, E = 3S*dp - sv*d
          t3   = chse_pkg::NUM_W'(s.dp) <<< chse_pkg::FRAC_BITS;
          n.x1 = s.x1 - (t3 <<< 1);
          n.x2 = (t3 <<< 1) + t3 - s.x2;
        end
        3: begin
          n.pa = chse_pkg::mul_part(s.x0, chse_pkg::MUL_W'(s.d));
          n.pb = chse_pkg::mul_part(s.x2, chse_pkg::MUL_W'(s.d));
        end
        4: begin
          n.x0 = chse_pkg::mul_sum(s.pa, '0);
          n.x2 = chse_pkg::mul_sum(s.pb, '0);
        end
        5: begin
          n.pa = chse_pkg::mul_part(s.x0, chse_pkg::MUL_W'(s.v0));
          n.pb = chse_pkg::mul_part(s.x0, chse_pkg::MUL_W'(s.p0));
        end
        6: begin
          n.x3 = chse_pkg::mul_sum(s.pa, '0);
          n.x4 = chse_pkg::mul_sum(s.pb, '0);
        end
        7: begin
          // horner coefficients in u, highest first in x1
          a3x = (s.x1 <<< 1) + s.x1;
          case (s.cmd)
            chse_pkg::CMD_VALUE: begin
              n.den = s.x0 <<< chse_pkg::FRAC_BITS;
              n.x4  = s.x4 <<< chse_pkg::FRAC_BITS;
            end
            chse_pkg::CMD_SLOPE: begin
              n.den = s.x0;
              n.x1  = '0;
              n.x2  = a3x;
              n.x3  = s.x2 <<< 1;
              n.x4  = s.x3;
            end
            default: begin
              n.den = s.x0;
              n.x1  = '0;
              n.x2  = '0;
              n.x3  = a3x <<< (chse_pkg::FRAC_BITS + 1);
              n.x4  = s.x2 <<< (chse_pkg::FRAC_BITS + 1);
            end
          endcase
        end
        8, 10, 12: begin
          n.pa = chse_pkg::mul_part(s.x1, chse_pkg::MUL_W'(s.u));
        end
        9:  n.x1 = chse_pkg::mul_sum(s.pa, s.x2);
        11: n.x1 = chse_pkg::mul_sum(s.pa, s.x3);
        13: n.x1 = chse_pkg::mul_sum(s.pa, s.x4);
        default: n = s;
      endcase
      st_d[k] = n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < chse_pkg::POLY_NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < chse_pkg::POLY_NS; k++) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_pd_o.num  = st_q[chse_pkg::POLY_NS-1].x1;
  assign out_pd_o.den  = st_q[chse_pkg::POLY_NS-1].den;
  assign out_pd_o.bad  = st_q[chse_pkg::POLY_NS-1].bad;
  assign out_pd_o.zero = (st_q[chse_pkg::POLY_NS-1].cmd == chse_pkg::CMD_NONE);

endmodule

[hdl/chse_div.sv]
module chse_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  chse_pkg::pd_t  in_pd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output chse_pkg::rsp_t out_rsp_o
);

  // sign split, range check, one quotient bit per stage, round and clamp
  typedef struct packed {
    logic                          neg;
    logic                          bad;
    logic                          zero;
    logic                          ovf;
    logic [chse_pkg::REM_W-1:0]    r;
    logic [chse_pkg::REM_W-1:0]    den;
    logic [chse_pkg::QUO_W-1:0]    q;
    chse_pkg::rsp_t                rsp;
  } dv_t;

  dv_t                          st_q [chse_pkg::DIV_NS];
  dv_t                          st_d [chse_pkg::DIV_NS];
  logic [chse_pkg::DIV_NS-1:0]  v_q;
  logic [chse_pkg::DIV_NS:0]    rdy;

  always_comb begin
    rdy[chse_pkg::DIV_NS] = out_ready_i;
    for (int k = chse_pkg::DIV_NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[chse_pkg::DIV_NS-1];

  always_comb begin
    dv_t                          s;
    dv_t                          n;
    logic [chse_pkg::NUM_W-1:0]   mag;
    logic [chse_pkg::REM_W-1:0]   sh;
    logic [chse_pkg::QUO_W:0]     qr;
    logic [chse_pkg::QUO_W:0]     lim;
    logic                         rnd;

    s       = '0;
    sh      = '0;
    qr      = '0;
    lim     = '0;
    rnd     = 1'b0;
    n       = '0;
    n.neg   = in_pd_i.num[chse_pkg::NUM_W-1];
    n.bad   = in_pd_i.bad;
    n.zero  = in_pd_i.zero;
    mag     = n.neg ? chse_pkg::NUM_W'(-in_pd_i.num) : in_pd_i.num;
    n.r     = {{chse_pkg::QUO_W{1'b0}}, mag};
    n.den   = {{chse_pkg::QUO_W{1'b0}}, in_pd_i.den};
    st_d[0] = n;

    for (int k = 1; k < chse_pkg::DIV_NS; k++) begin
      s = st_q[k-1];
      n = s;
      if (k == 1) begin
        n.ovf = (s.r >= (s.den << chse_pkg::QUO_W));
      end else if (k < chse_pkg::DIV_NS - 1) begin
        sh = s.den << (chse_pkg::DIV_NS - 2 - k);
        if (s.r >= sh) begin
          n.r = s.r - sh;
          n.q = s.q | (chse_pkg::QUO_W'(1) << (chse_pkg::DIV_NS - 2 - k));
        end
      end else begin
        // round half up on the magnitude, then clamp
        rnd = ((s.r << 1) >= s.den);
        qr  = {1'b0, s.q} + (chse_pkg::QUO_W + 1)'(rnd);
        lim = s.neg ? (chse_pkg::QUO_W + 1)'(34'h0_8000_0000)
                    : (chse_pkg::QUO_W + 1)'(34'h0_7fff_ffff);
        n.rsp = '0;
        if (s.bad) begin
          n.rsp.bad_interval = 1'b1;
        end else if (!s.zero) begin
          if (s.ovf || (qr > lim)) begin
            n.rsp.saturated    = 1'b1;
            n.rsp.result_value = s.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
          end else begin
            n.rsp.result_value = s.neg ? -qr[31:0] : qr[31:0];
          end
        end
      end
      st_d[k] = n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < chse_pkg::DIV_NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < chse_pkg::DIV_NS; k++) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_rsp_o = st_q[chse_pkg::DIV_NS-1].rsp;

endmodule

[hdl/cubic_hermite_segment_eval.sv]
// channel  | valid       | ready       | payload
// request  | in_valid_i  | in_ready_o  | in_req_i   (chse_pkg::req_t)
// result   | out_valid_o | out_ready_i | out_rsp_o  (chse_pkg::rsp_t)
//
// one request per cycle while out_ready_i is high; a request passes 14 polynomial stages
// (three horner multiply-adds in u, each split into partial products and a sum)
// and 36 divider stages, one quotient bit per stage over 33 bits
// rst_ni clears only the stage valid bits, no clearing pass
// a stall holds only stages that are full, bubbles still close up
module cubic_hermite_segment_eval (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  chse_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output chse_pkg::rsp_t out_rsp_o
);

  logic          pd_valid;
  logic          pd_ready;
  chse_pkg::pd_t pd;

  chse_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (pd_valid),
    .out_ready_i (pd_ready),
    .out_pd_o    (pd)
  );

  chse_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pd_valid),
    .in_ready_o  (pd_ready),
    .in_pd_i     (pd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("pipe stalls while the result side is ready");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.bad_interval |->
      out_rsp_o.result_value == 32'sd0 && !out_rsp_o.saturated)
    else $error("bad interval result not cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.saturated |->
      out_rsp_o.result_value == 32'sh7fff_ffff ||
      out_rsp_o.result_value == 32'sh8000_0000)
    else $error("saturated result not at a limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pd_valid && !pd_ready |=> pd_valid && $stable(pd))
    else $error("internal handoff lost or changed");

endmodule
